### rtl/ppc_pkg.sv
// Shared types and constants for the polygon plane clipper.
// No dependencies; imported by every other file of the block.
`default_nettype none
package ppc_pkg;
    localparam int NCOMP         = 5;
    localparam int COMP_W        = 32;
    localparam int NORM_W        = 16;
    localparam int FRAC_W        = 16;
    localparam int MUL_A_W       = 34;
    localparam int MUL_B_W       = 17;
    localparam int MUL_P_W       = MUL_A_W + MUL_B_W;
    localparam int DOT_SHIFT     = 14;
    localparam int CNT_W         = 6;
    localparam int DEF_MAX_VERTS = 32;
    localparam int MAX_OUT       = 4;

    typedef enum logic [1:0] {
        CFG_NORMAL_X = 2'd0,
        CFG_NORMAL_Y = 2'd1,
        CFG_NORMAL_Z = 2'd2,
        CFG_OFFSET   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_DOT, S_DOTW, S_DIST, S_EDGE, S_PUSHA, S_CROSS,
        S_DIVW, S_MUL, S_MULW, S_PUSHM, S_NEXT, S_FINAL
    } t_state;

    typedef struct packed {
        logic start;
        logic clr;
    } t_mul_ctl;
endpackage
`default_nettype wire

### rtl/ppc_mul.sv
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle.
// Depends on ppc_pkg.
`default_nettype none
module ppc_mul (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  ppc_pkg::t_mul_ctl                i_ctl,
    input  wire signed [ppc_pkg::MUL_A_W-1:0] i_a,
    input  wire signed [ppc_pkg::MUL_B_W-1:0] i_b,
    output logic                             o_done,
    output logic signed [ppc_pkg::MUL_P_W-1:0] o_acc
);
    import ppc_pkg::*;

    logic signed [MUL_P_W-1:0] r_ma, n_ma, r_acc, n_acc;
    logic [MUL_B_W-1:0]        r_mb, n_mb;
    logic [4:0]                r_cnt, n_cnt;

    always_comb begin
        n_ma  = r_ma;
        n_mb  = r_mb;
        n_acc = r_acc;
        n_cnt = r_cnt;
        if (i_ctl.start) begin
            n_ma  = MUL_P_W'(i_a);
            n_mb  = i_b;
            n_cnt = 5'(MUL_B_W);
            if (i_ctl.clr) begin
                n_acc = '0;
            end
        end else if (r_cnt != 5'd0) begin
            if (r_mb[0]) begin
                n_acc = (r_cnt == 5'd1) ? r_acc - r_ma : r_acc + r_ma;
            end
            n_ma  = r_ma <<< 1;
            n_mb  = r_mb >> 1;
            n_cnt = r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_acc <= n_acc;
    end

    assign o_done = (r_cnt == 5'd0);
    assign o_acc  = r_acc;
endmodule
`default_nettype wire

### rtl/ppc_div.sv
// Restoring divider for the edge fraction, one quotient bit per cycle.
// Depends on ppc_pkg.
`default_nettype none
module ppc_div (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire [ppc_pkg::COMP_W-1:0]   i_num,
    input  wire [ppc_pkg::COMP_W:0]     i_den,
    output logic                        o_done,
    output logic [ppc_pkg::FRAC_W-1:0]  o_q
);
    import ppc_pkg::*;

    logic [COMP_W+1:0] r_rem, n_rem, w_t;
    logic [COMP_W:0]   r_den, n_den;
    logic [FRAC_W-1:0] r_q, n_q;
    logic [4:0]        r_cnt, n_cnt;

    always_comb begin
        n_rem = r_rem;
        n_den = r_den;
        n_q   = r_q;
        n_cnt = r_cnt;
        w_t   = {r_rem[COMP_W:0], 1'b0};
        if (i_start) begin
            n_rem = {2'b00, i_num};
            n_den = i_den;
            n_q   = '0;
            n_cnt = 5'(FRAC_W);
        end else if (r_cnt != 5'd0) begin
            if (w_t >= {1'b0, r_den}) begin
                n_rem = w_t - {1'b0, r_den};
                n_q   = {r_q[FRAC_W-2:0], 1'b1};
            end else begin
                n_rem = w_t;
                n_q   = {r_q[FRAC_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_q   <= n_q;
    end

    assign o_done = (r_cnt == 5'd0);
    assign o_q    = r_q;
endmodule
`default_nettype wire

### rtl/polygon_plane_clip_top.sv
// Top level of the polygon plane clipper: sequencer, vertex stores, output register.
// Depends on ppc_pkg, ppc_mul and ppc_div.
//
// One vertex is taken per transfer and clipped against the configured plane,
// keeping the front side. A vertex's distance takes three serial multiplies,
// and each edge that crosses the plane adds a serial divide and five serial
// multiplies; all of these multiplies share the single bit-serial multiplier.
// Results are held back by one vertex so that the final one of a polygon
// carries is_last.
`default_nettype none
module polygon_plane_clip_top #(
    parameter int MAX_VERTS = ppc_pkg::DEF_MAX_VERTS
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_idx,
    input  wire [31:0] i_cfg_data,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire signed [31:0] i_pos_x,
    input  wire signed [31:0] i_pos_y,
    input  wire signed [31:0] i_pos_z,
    input  wire signed [31:0] i_tex_s,
    input  wire signed [31:0] i_tex_t,
    input  wire        i_last_vertex,
    output logic       o_valid,
    input  wire        i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_out_s,
    output logic signed [31:0] o_out_t,
    output logic       o_is_last,
    output logic       o_is_empty,
    output logic [5:0] o_vertex_number,
    output logic       o_too_many
);
    import ppc_pkg::*;

    typedef logic [NCOMP-1:0][COMP_W-1:0] t_vtx;

    t_state r_state, n_state;
    logic signed [NORM_W-1:0] r_nx, r_ny, r_nz;
    logic signed [COMP_W-1:0] r_off;
    t_vtx r_v, n_v, r_first, n_first, r_prev, n_prev, r_held, n_held, r_mid, n_mid;
    t_vtx r_ox, n_ox;
    logic signed [COMP_W-1:0] r_d, n_d, r_fd, n_fd, r_pd, n_pd;
    logic r_vlast, n_vlast, r_hv, n_hv, r_hf, n_hf, r_edge, n_edge;
    logic [2:0] r_k, n_k, r_c, n_c;
    logic [CNT_W-1:0] r_cnt, n_cnt, w_cnt_inc;
    logic r_ov, n_ov, r_olast, n_olast, r_oempty, n_oempty, r_otoo, n_otoo;
    logic [CNT_W-1:0] r_onum, n_onum;

    t_mul_ctl w_mctl;
    logic signed [MUL_A_W-1:0] w_ma;
    logic signed [MUL_B_W-1:0] w_mb;
    logic w_mdone, w_dstart, w_ddone, w_ofree, w_emit_held;
    logic signed [MUL_P_W-1:0] w_acc;
    logic [FRAC_W-1:0] w_q;
    t_vtx w_a, w_b;
    logic signed [COMP_W-1:0] w_da, w_db, w_dsat;
    logic [COMP_W-1:0] w_ua, w_ub;
    logic signed [MUL_P_W-DOT_SHIFT:0] w_dist;
    logic signed [NORM_W-1:0] w_norm;

    ppc_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_mctl), .i_a(w_ma), .i_b(w_mb),
        .o_done(w_mdone), .o_acc(w_acc)
    );

    ppc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart), .i_num(w_ua),
        .i_den({1'b0, w_ua} + {1'b0, w_ub}), .o_done(w_ddone), .o_q(w_q)
    );

    always_comb begin
        w_a  = r_edge ? r_v : r_prev;
        w_b  = r_edge ? r_first : r_v;
        w_da = r_edge ? r_d : r_pd;
        w_db = r_edge ? r_fd : r_d;
        w_ua = w_da[COMP_W-1] ? COMP_W'(-w_da) : COMP_W'(w_da);
        w_ub = w_db[COMP_W-1] ? COMP_W'(-w_db) : COMP_W'(w_db);
        unique case (r_c[1:0])
            2'd0:    w_norm = r_nx;
            2'd1:    w_norm = r_ny;
            default: w_norm = r_nz;
        endcase
        w_dist = (MUL_P_W-DOT_SHIFT+1)'(w_acc >>> DOT_SHIFT)
               - (MUL_P_W-DOT_SHIFT+1)'(r_off);
        if (w_dist > (MUL_P_W-DOT_SHIFT+1)'(64'sd2147483647)) begin
            w_dsat = 32'sh7FFFFFFF;
        end else if (w_dist < -(MUL_P_W-DOT_SHIFT+1)'(64'sd2147483648)) begin
            w_dsat = 32'sh80000000;
        end else begin
            w_dsat = COMP_W'(w_dist);
        end
        w_cnt_inc = (r_cnt == 6'd63) ? r_cnt : r_cnt + 6'd1;
        w_ofree   = !r_ov || !i_stall;
        w_emit_held = r_hv && (r_k < 3'(MAX_OUT));
    end

    always_comb begin
        n_state = r_state;
        n_v = r_v; n_first = r_first; n_prev = r_prev; n_held = r_held; n_mid = r_mid;
        n_d = r_d; n_fd = r_fd; n_pd = r_pd;
        n_vlast = r_vlast; n_hv = r_hv; n_hf = r_hf; n_edge = r_edge;
        n_k = r_k; n_c = r_c; n_cnt = r_cnt;
        n_ov = r_ov && i_stall;
        n_ox = r_ox; n_olast = r_olast; n_oempty = r_oempty;
        n_onum = r_onum; n_otoo = r_otoo;
        w_mctl = '0;
        w_ma = MUL_A_W'(signed'(r_v[r_c]));
        w_mb = MUL_B_W'(w_norm);
        w_dstart = 1'b0;
        o_stall = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_v = {i_tex_t, i_tex_s, i_pos_z, i_pos_y, i_pos_x};
                    n_vlast = i_last_vertex;
                    n_k = '0;
                    n_c = '0;
                    n_state = S_DOT;
                end
            end
            S_DOT: begin
                w_mctl.start = 1'b1;
                w_mctl.clr = (r_c == 3'd0);
                n_state = S_DOTW;
            end
            S_DOTW: begin
                if (w_mdone) begin
                    if (r_c == 3'd2) begin
                        n_state = S_DIST;
                    end else begin
                        n_c = r_c + 3'd1;
                        n_state = S_DOT;
                    end
                end
            end
            S_DIST: begin
                n_d = w_dsat;
                n_edge = 1'b0;
                if (r_hf) begin
                    n_state = S_EDGE;
                end else begin
                    n_first = r_v;
                    n_fd = w_dsat;
                    n_hf = 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_EDGE: begin
                n_state = w_da[COMP_W-1] ? S_CROSS : S_PUSHA;
            end
            S_PUSHA, S_PUSHM: begin
                if (!w_emit_held || w_ofree) begin
                    if (w_emit_held) begin
                        n_ov = 1'b1;
                        n_ox = r_held;
                        n_olast = 1'b0;
                        n_oempty = 1'b0;
                        n_cnt = w_cnt_inc;
                        n_onum = w_cnt_inc;
                        n_otoo = (w_cnt_inc >= CNT_W'(MAX_VERTS));
                    end
                    if (r_hv) begin
                        n_k = r_k + 3'd1;
                    end
                    n_held = (r_state == S_PUSHA) ? w_a : r_mid;
                    n_hv = 1'b1;
                    n_state = (r_state == S_PUSHA) ? S_CROSS : S_NEXT;
                end
            end
            S_CROSS: begin
                if (w_da != '0 && w_db != '0 && (w_da[COMP_W-1] != w_db[COMP_W-1])) begin
                    w_dstart = 1'b1;
                    n_state = S_DIVW;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_DIVW: begin
                if (w_ddone) begin
                    n_c = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                w_mctl.start = 1'b1;
                w_mctl.clr = 1'b1;
                w_ma = MUL_A_W'(signed'(w_b[r_c])) - MUL_A_W'(signed'(w_a[r_c]));
                w_mb = MUL_B_W'({1'b0, w_q});
                n_state = S_MULW;
            end
            S_MULW: begin
                if (w_mdone) begin
                    n_mid[r_c] = w_a[r_c] + w_acc[FRAC_W+COMP_W-1:FRAC_W];
                    if (r_c == 3'(NCOMP-1)) begin
                        n_state = S_PUSHM;
                    end else begin
                        n_c = r_c + 3'd1;
                        n_state = S_MUL;
                    end
                end
            end
            S_NEXT: begin
                if (r_edge) begin
                    n_state = S_FINAL;
                end else begin
                    n_prev = r_v;
                    n_pd = r_d;
                    if (r_vlast) begin
                        n_edge = 1'b1;
                        n_state = S_EDGE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FINAL: begin
                if ((r_hv && !w_emit_held) || w_ofree) begin
                    if (!r_hv) begin
                        n_ov = 1'b1;
                        n_ox = '0;
                        n_olast = 1'b1;
                        n_oempty = 1'b1;
                        n_onum = '0;
                        n_otoo = 1'b0;
                    end else if (w_emit_held) begin
                        n_ov = 1'b1;
                        n_ox = r_held;
                        n_olast = 1'b1;
                        n_oempty = 1'b0;
                        n_onum = w_cnt_inc;
                        n_otoo = (w_cnt_inc >= CNT_W'(MAX_VERTS));
                    end
                    n_hv = 1'b0;
                    n_hf = 1'b0;
                    n_cnt = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hv    <= 1'b0;
            r_hf    <= 1'b0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_k     <= '0;
            r_nx    <= '0;
            r_ny    <= '0;
            r_nz    <= 16'sd16384;
            r_off   <= '0;
        end else begin
            r_state <= n_state;
            r_hv    <= n_hv;
            r_hf    <= n_hf;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
            r_k     <= n_k;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_NORMAL_X: r_nx  <= i_cfg_data[NORM_W-1:0];
                    CFG_NORMAL_Y: r_ny  <= i_cfg_data[NORM_W-1:0];
                    CFG_NORMAL_Z: r_nz  <= i_cfg_data[NORM_W-1:0];
                    CFG_OFFSET:   r_off <= i_cfg_data;
                    default:      r_off <= r_off;
                endcase
            end
        end
        r_v <= n_v; r_first <= n_first; r_prev <= n_prev; r_held <= n_held;
        r_mid <= n_mid; r_d <= n_d; r_fd <= n_fd; r_pd <= n_pd;
        r_vlast <= n_vlast; r_edge <= n_edge; r_c <= n_c;
        r_ox <= n_ox; r_olast <= n_olast; r_oempty <= n_oempty;
        r_onum <= n_onum; r_otoo <= n_otoo;
    end

    assign o_valid = r_ov;
    assign o_out_x = r_ox[0];
    assign o_out_y = r_ox[1];
    assign o_out_z = r_ox[2];
    assign o_out_s = r_ox[3];
    assign o_out_t = r_ox[4];
    assign o_is_last = r_olast;
    assign o_is_empty = r_oempty;
    assign o_vertex_number = r_onum;
    assign o_too_many = r_otoo;

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oempty) |-> (r_onum == '0 && r_ox == '0 && r_olast))
        else $error("empty result carries data");
    a_num_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_oempty) |-> (r_onum != '0))
        else $error("vertex result without a count");
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_hf) |-> !r_hv)
        else $error("held vertex outside a polygon");
    a_seq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= 3'd5)
        else $error("too many results for one vertex");
endmodule
`default_nettype wire
